// ----- rtl/stm_pkg.sv -----
package stm_pkg;

	// Quotient width of the pH scaling: the quotient stays below 4480.
	localparam int unsigned QUO_W     = 13;
	localparam int unsigned SCALE_NUM = 4480;

	localparam int unsigned SUM_OUT_W = 16;
	localparam int unsigned PH_W      = 14;
	localparam int unsigned OFFSET_W  = 11;

	// Commands from controller to datapath
	typedef struct packed {
		logic wr;    // store the accepted sample, rewind the scan
		logic rd;    // read one window entry
		logic trim;  // sum minus min minus max
		logic mult;  // scale the trimmed sum
		logic div;   // reciprocal multiply for the window divide
		logic load;  // move the result into the output register
	} stm_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_full;
	} stm_stat_t;

	// Result beat, first field in the highest bits
	typedef struct packed {
		logic signed [PH_W-1:0]  ph_value;
		logic [SUM_OUT_W-1:0]    trimmed_sum;
	} stm_res_t;

endpackage

// ----- rtl/stm_ctrl.sv -----
module stm_ctrl
	import stm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  stm_stat_t stat,
	output stm_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		DRAIN,
		TRIM,
		MULT,
		DIV,
		LOAD
	} state_t;

	state_t state_q;

	// Command decode
	always_comb begin
		cmd      = '0;
		cmd.wr   = (state_q == IDLE) && in_valid;
		cmd.rd   = (state_q == SCAN);
		cmd.trim = (state_q == TRIM);
		cmd.mult = (state_q == MULT);
		cmd.div  = (state_q == DIV);
		cmd.load = (state_q == LOAD) && !stat.out_full;
	end

	assign in_ready = (state_q == IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= SCAN;
				end
				SCAN: begin
					if (stat.scan_last) state_q <= DRAIN;
				end
				DRAIN: state_q <= TRIM;
				TRIM:  state_q <= MULT;
				MULT:  state_q <= DIV;
				DIV:   state_q <= LOAD;
				LOAD: begin
					if (!stat.out_full) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/stm_dp.sv -----
module stm_dp
	import stm_pkg::*;
#(
	parameter int unsigned WINDOW_LEN  = 40,
	parameter int unsigned SAMPLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stm_cmd_t                   cmd,
	output stm_stat_t                  stat,
	input  logic [SAMPLE_BITS-1:0]     sample,
	input  logic signed [OFFSET_W-1:0] ph_offset,
	output logic                       out_valid,
	input  logic                       out_ready,
	output stm_res_t                   out_data
);

	localparam int unsigned IDX_W   = $clog2(WINDOW_LEN);
	localparam int unsigned SUM_W   = SAMPLE_BITS + IDX_W;
	localparam int unsigned PROD_W  = SUM_W + QUO_W;
	localparam int unsigned Y_W     = PROD_W - SAMPLE_BITS;
	localparam int unsigned DIVISOR = WINDOW_LEN - 2;

	// Rounded-up reciprocal of the divisor; exact for every Y_W-bit dividend
	localparam int unsigned RSHIFT  = Y_W + $clog2(DIVISOR);
	localparam int unsigned RCP_W   = Y_W + 1;
	localparam int unsigned QP_W    = Y_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << RSHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

	// Window memory and per-entry valid bits
	logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]  vld_q;
	logic [IDX_W-1:0]       wslot_q;
	logic [IDX_W-1:0]       rd_idx_q;

	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   rd_vld_s1;
	logic                   rd_s1;
	logic                   first_s1;

	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic [SUM_W-1:0]       trim_q;

	logic [Y_W-1:0]         scl_q;
	logic [QUO_W-1:0]       quo_q;

	logic                   out_valid_q;
	stm_res_t               out_data_q;

	logic [SAMPLE_BITS-1:0] rd_val;
	logic [PROD_W-1:0]      prod;
	logic [QP_W-1:0]        qprod;

	// Memory write on accept, registered read during the scan
	always_ff @(posedge clk) begin
		if (cmd.wr) mem[wslot_q] <= sample;
		if (cmd.rd) begin
			rd_data_s1 <= mem[rd_idx_q];
			rd_vld_s1  <= vld_q[rd_idx_q];
		end
	end

	// Write slot, valid bits, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wslot_q  <= '0;
			rd_idx_q <= '0;
			rd_s1    <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			rd_s1    <= cmd.rd;
			first_s1 <= cmd.rd && (rd_idx_q == '0);
			if (cmd.wr) begin
				vld_q[wslot_q] <= 1'b1;
				wslot_q        <= (wslot_q == IDX_W'(WINDOW_LEN - 1)) ? '0 : wslot_q + 1'b1;
				rd_idx_q       <= '0;
			end else if (cmd.rd) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	assign stat.scan_last = (rd_idx_q == IDX_W'(WINDOW_LEN - 1));

	// Entries never written read as zero
	assign rd_val = rd_vld_s1 ? rd_data_s1 : '0;

	// Sum, min and max over the scan
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (first_s1) begin
				sum_q <= SUM_W'(rd_val);
				lo_q  <= rd_val;
				hi_q  <= rd_val;
			end else begin
				sum_q <= sum_q + SUM_W'(rd_val);
				if (rd_val < lo_q) lo_q <= rd_val;
				if (rd_val > hi_q) hi_q <= rd_val;
			end
		end
		if (cmd.trim) trim_q <= sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
	end

	// Scale: floor(trim*4480 / 2^SAMPLE_BITS), then divide by WINDOW_LEN-2
	assign prod  = PROD_W'(trim_q) * PROD_W'(SCALE_NUM);
	assign qprod = QP_W'(scl_q) * QP_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.mult) scl_q <= Y_W'(prod >> SAMPLE_BITS);
		if (cmd.div)  quo_q <= QUO_W'(qprod >> RSHIFT);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q.trimmed_sum <= SUM_OUT_W'(trim_q);
			out_data_q.ph_value    <= PH_W'($signed({1'b0, quo_q})) + PH_W'(ph_offset);
		end
	end

	assign stat.out_full = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

endmodule

// ----- rtl/sliding_trimmed_mean_ph.sv -----
// Channel  Dir  Signals                          Beat contents (low bit up)
// s_*      in   s_tvalid s_tready s_tdata        sample
// m_*      out  m_tvalid m_tready m_tdata        trimmed_sum, ph_value
// apb      in   psel penable pwrite paddr pwdata ph_offset at address 0
//
// Each sample passes through the accept state, one memory read per window entry,
// then the drain, trim, scale, reciprocal divide and load states. The next sample is
// taken once the previous result is in the output register. While m_tready holds a
// beat, a finished result waits in the datapath and the input stays closed until
// the output register frees. After reset, entries not yet written read as zero
// through per-entry valid bits.
module sliding_trimmed_mean_ph
	import stm_pkg::*;
#(
	parameter int unsigned WINDOW_LEN  = 40,
	parameter int unsigned SAMPLE_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [31:0]                          m_tdata,   // trimmed_sum, ph_value
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	localparam logic REG_PH_OFFSET = 1'b0;

	logic signed [OFFSET_W-1:0] ph_offset_q;
	stm_cmd_t                   cmd;
	stm_stat_t                  stat;
	stm_res_t                   res;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_offset_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PH_OFFSET)) begin
			ph_offset_q <= pwdata[OFFSET_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PH_OFFSET) ? 32'(ph_offset_q) : '0;

	stm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stm_dp #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (s_tdata[SAMPLE_BITS-1:0]),
		.ph_offset (ph_offset_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = 32'(res);

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
	import stm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LEN   = 40;
	localparam int SAMPLE_BITS  = 10;
	localparam int DATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int END_SETTLE   = 80;
	localparam int ITEMS_PER_PH = 570;

	// register map
	localparam logic [2:0] ADDR_PH_OFFSET = 3'd0;
	localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	// Expected-result store and window predictor
	class ph_window_board;
		logic [SAMPLE_BITS-1:0]     window_q[WINDOW_LEN];
		int unsigned                slot;
		logic signed [OFFSET_W-1:0] offset_q;
		stm_res_t                   pending[$];
		int unsigned                errors;

		function new();
			foreach (window_q[i]) window_q[i] = '0;
			slot     = 0;
			offset_q = '0;
			errors   = 0;
		endfunction

		function void set_offset(input logic [OFFSET_W-1:0] value);
			offset_q = value;
		endfunction

		// write the sample into the ring, then predict trimmed sum and pH
		function void take_sample(input logic [DATA_W-1:0] data);
			int unsigned total;
			int unsigned lo;
			int unsigned hi;
			longint      ph;
			stm_res_t    want;
			window_q[slot] = data[SAMPLE_BITS-1:0];
			slot = (slot + 1 == WINDOW_LEN) ? 0 : slot + 1;
			total = 0;
			lo = window_q[0];
			hi = window_q[0];
			foreach (window_q[i]) begin
				total += window_q[i];
				if (window_q[i] < lo) lo = window_q[i];
				if (window_q[i] > hi) hi = window_q[i];
			end
			total = total - lo - hi;
			ph = (longint'(total) * longint'(SCALE_NUM))
				/ (longint'(WINDOW_LEN - 2) << SAMPLE_BITS);
			ph = ph + longint'(offset_q);
			if (ph > (longint'(1) << (PH_W - 1)) - 1) ph = (longint'(1) << (PH_W - 1)) - 1;
			if (ph < -(longint'(1) << (PH_W - 1))) ph = -(longint'(1) << (PH_W - 1));
			want.trimmed_sum = total[SUM_OUT_W-1:0];
			want.ph_value    = ph[PH_W-1:0];
			pending.push_back(want);
		endfunction

		// compare a result beat with the oldest prediction
		function void check_beat(input logic [31:0] beat);
			stm_res_t got;
			stm_res_t want;
			got = beat[$bits(stm_res_t)-1:0];
			if (pending.size() == 0) begin
				$error("result beat %h with no sample pending", beat);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.trimmed_sum !== want.trimmed_sum) begin
				$error("trimmed_sum: expected %0d, got %0d", want.trimmed_sum, got.trimmed_sum);
				errors++;
			end
			if (got.ph_value !== want.ph_value) begin
				$error("ph_value: expected %0d, got %0d", want.ph_value, got.ph_value);
				errors++;
			end
		endfunction
	endclass

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [31:0]         m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [2:0]          paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	ph_window_board      board = new();
	int                  src_gap_pct    = 13;
	int                  sink_stall_pct = 71;
	int unsigned         cycle_count    = 0;
	logic [SAMPLE_BITS-1:0] last_sample = '0;

	sliding_trimmed_mean_ph #(
		.WINDOW_LEN (WINDOW_LEN),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_beat(m_tdata);
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// one sample beat, with an optional random gap ahead of it
	task automatic send_sample(input logic [DATA_W-1:0] data);
		if ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_sample(data);
		last_sample = data[SAMPLE_BITS-1:0];
	endtask

	// hold off the sender until every expected result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// setup + access phases, then idle
	task automatic apb_write(input logic [2:0] addr, input logic [OFFSET_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {{(32 - OFFSET_W){value[OFFSET_W-1]}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_PH_OFFSET) board.set_offset(value);
		@(posedge clk);
	endtask

	task automatic set_offset_idle(input logic [OFFSET_W-1:0] value);
		drain_results();
		apb_write(ADDR_PH_OFFSET, value);
	endtask

	// mostly uniform, with extremes and repeats to hit tied min/max
	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int pick;
		int delta;
		pick = $urandom_range(99);
		if (pick < 55) return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
		if (pick < 70) return $urandom_range(1) ? SAMPLE_MAX : '0;
		if (pick < 85) return last_sample;
		delta = int'($urandom_range(16)) - 8;
		if (int'(last_sample) + delta < 0) return '0;
		if (int'(last_sample) + delta > int'(SAMPLE_MAX)) return SAMPLE_MAX;
		return SAMPLE_BITS'(int'(last_sample) + delta);
	endfunction

	task automatic run_random(input int n_items, input int gap_pct, input int stall_pct,
			input logic [OFFSET_W-1:0] offset);
		int sent;
		int run_len;
		logic [SAMPLE_BITS-1:0] run_val;
		src_gap_pct    = gap_pct;
		sink_stall_pct = stall_pct;
		set_offset_idle(offset);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 2) begin
				// constant run long enough to fill the whole window
				run_len = $urandom_range(WINDOW_LEN + 10, WINDOW_LEN);
				case ($urandom_range(2))
					0: run_val = '0;
					1: run_val = SAMPLE_MAX;
					default: run_val = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
				endcase
				repeat (run_len) send_sample(DATA_W'(run_val));
				sent += run_len;
			end else begin
				send_sample(DATA_W'(pick_sample()));
				sent++;
			end
			// occasional recalibration with any 11-bit pattern
			if ($urandom_range(199) == 0) set_offset_idle(OFFSET_W'($urandom()));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh window, tied extremes, padding bits above the sample set
		send_sample(DATA_W'(SAMPLE_MAX));
		send_sample('0);
		send_sample(DATA_W'(1));
		send_sample('1);
		send_sample(DATA_W'(16'h0400));
		send_sample(DATA_W'(10'h2AA));
		send_sample(DATA_W'(10'h155));
		send_sample(DATA_W'(512));

		// positive offset of 512
		set_offset_idle(OFFSET_W'(512));
		send_sample(DATA_W'(SAMPLE_MAX));
		send_sample(DATA_W'(700));

		// write to an unmapped register leaves the offset alone
		drain_results();
		apb_write(ADDR_UNMAPPED, OFFSET_W'(5));
		send_sample(DATA_W'(300));
		send_sample(DATA_W'(SAMPLE_MAX));

		// negative offset of -512, then full 11-bit extremes
		set_offset_idle(-OFFSET_W'(512));
		send_sample('0);
		send_sample(DATA_W'(900));
		set_offset_idle(OFFSET_W'(1023));
		send_sample(DATA_W'(SAMPLE_MAX));
		send_sample(DATA_W'(40));
		set_offset_idle(OFFSET_W'(-1024));
		send_sample('0);
		send_sample(DATA_W'(1));

		run_random(ITEMS_PER_PH, 13, 71, OFFSET_W'(int'($urandom_range(1024)) - 512));
		run_random(ITEMS_PER_PH, 71, 13, OFFSET_W'(512));
		run_random(ITEMS_PER_PH, 0, 0, -OFFSET_W'(512));

		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/stm_pkg.sv
rtl/stm_ctrl.sv
rtl/stm_dp.sv
rtl/sliding_trimmed_mean_ph.sv
tb/sv/testbench.sv
